// ===== rtl/rc4_pkg.sv =====
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants for the rc4 stream cipher unit: request codes,
// sbox geometry and the sequencer state encoding.
// ----------------------------------------------------------------------------
package rc4_pkg;

  // request codes carried in req_type
  localparam logic [1:0] REQ_KEY      = 2'd0;
  localparam logic [1:0] REQ_SCHEDULE = 2'd1;
  localparam logic [1:0] REQ_DATA     = 2'd2;

  // sbox geometry
  localparam int         SBOX_DEPTH = 256;
  localparam logic [7:0] SBOX_LAST  = 8'hFF;

  // key length register
  localparam logic [8:0] KEY_LEN_RESET = 9'd16;

  // result status codes
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NO_SCHED = 1'b1;

  // sequencer states, one-hot
  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_INIT   = 11'b000_0000_0010,
    S_KS_RD  = 11'b000_0000_0100,
    S_KS_J   = 11'b000_0000_1000,
    S_KS_WN  = 11'b000_0001_0000,
    S_KS_WJ  = 11'b000_0010_0000,
    S_DT_RD  = 11'b000_0100_0000,
    S_DT_J   = 11'b000_1000_0000,
    S_DT_WI  = 11'b001_0000_0000,
    S_DT_WJ  = 11'b010_0000_0000,
    S_RESULT = 11'b100_0000_0000
  } state_t;

endpackage

// ===== rtl/rc4_ram.sv =====
// ----------------------------------------------------------------------------
// rc4_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data (old data on a same-address write).
// ----------------------------------------------------------------------------
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rc4_stream_cipher_unit.sv =====
// ----------------------------------------------------------------------------
// rc4_stream_cipher_unit
// RC4 engine with a key store and an sbox held in synchronous RAMs.
// ----------------------------------------------------------------------------
// One transaction is taken at a time and every transaction returns exactly
// one result. A key byte load, a data byte before any schedule, or an unused
// request type goes straight to the result state. A data byte makes four sbox
// accesses (read i, read j, write i with the keystream read, write j) around
// the single write port of the sbox RAM, then enters the result state. A
// schedule fills the sbox with the identity permutation, then runs 256 swap
// steps (read, j update, write n, write j), again bounded by the single
// sbox write port. The key length register is used at schedule time; 0
// counts as 1 and a value above KEY_STORE_DEPTH counts as KEY_STORE_DEPTH. A
// finished result waits in the output register while out_stall is high.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_unit
  import rc4_pkg::*;
#(
  parameter int KEY_STORE_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_wr_en,
  input  logic [8:0] cfg_wr_data,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] req_type,
  input  logic [7:0] key_index,
  input  logic [7:0] byte_in,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       status
);

  localparam int         KEY_AW      = $clog2(KEY_STORE_DEPTH);
  localparam logic [8:0] KEY_DEPTH_W = 9'(KEY_STORE_DEPTH);

  state_t            state;
  logic [7:0]        idx_i;
  logic [7:0]        idx_j;
  logic              scheduled;
  logic [8:0]        key_len;
  logic [7:0]        n;
  logic [KEY_AW-1:0] kpos;
  logic [7:0]        si;
  logic [7:0]        sj;
  logic [7:0]        t_addr;
  logic [7:0]        data_byte;
  logic [7:0]        res_byte;
  logic              res_status;

  logic              in_accept;
  logic              out_free;
  logic [8:0]        len_m1;
  logic [7:0]        jn;
  logic [7:0]        ks;

  // ram ports
  logic              sbox_we;
  logic [7:0]        sbox_waddr;
  logic [7:0]        sbox_wdata;
  logic [7:0]        sbox_raddr;
  logic [7:0]        sbox_rdata;
  logic              key_we;
  logic [7:0]        key_rdata;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // effective key length minus one
  always_comb begin
    priority if (key_len == 9'd0) begin
      len_m1 = 9'd0;
    end else if (key_len > KEY_DEPTH_W) begin
      len_m1 = KEY_DEPTH_W - 9'd1;
    end else begin
      len_m1 = key_len - 9'd1;
    end
  end

  // key store write on an accepted in-range key load
  assign key_we = in_accept && (req_type == REQ_KEY) && ({1'b0, key_index} < KEY_DEPTH_W);

  // j update for both schedule and generator steps
  always_comb begin
    if (state == S_KS_J) begin
      jn = idx_j + sbox_rdata + key_rdata;
    end else begin
      jn = idx_j + sbox_rdata;
    end
  end

  // keystream byte with forwarding around the pending swap write
  always_comb begin
    priority if (t_addr == idx_j) begin
      ks = si;
    end else if (t_addr == idx_i) begin
      ks = sj;
    end else begin
      ks = sbox_rdata;
    end
  end

  // sbox port control
  always_comb begin
    sbox_we    = 1'b0;
    sbox_waddr = n;
    sbox_wdata = n;
    sbox_raddr = idx_i;
    unique case (state)
      S_INIT: begin
        sbox_we = 1'b1;
      end
      S_KS_RD: begin
        sbox_raddr = n;
      end
      S_KS_J, S_DT_J: begin
        sbox_raddr = jn;
      end
      S_KS_WN: begin
        sbox_we    = 1'b1;
        sbox_wdata = sbox_rdata;
      end
      S_KS_WJ: begin
        sbox_we    = 1'b1;
        sbox_waddr = idx_j;
        sbox_wdata = si;
      end
      S_DT_WI: begin
        sbox_we    = 1'b1;
        sbox_waddr = idx_i;
        sbox_wdata = sbox_rdata;
        sbox_raddr = si + sbox_rdata;
      end
      S_DT_WJ: begin
        sbox_we    = 1'b1;
        sbox_waddr = idx_j;
        sbox_wdata = si;
      end
      S_IDLE, S_DT_RD, S_RESULT: begin
        sbox_we = 1'b0;
      end
      default: begin
        sbox_we = 1'b0;
      end
    endcase
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx_i     <= 8'd0;
      idx_j     <= 8'd0;
      scheduled <= 1'b0;
      key_len   <= KEY_LEN_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        key_len <= cfg_wr_data;
      end
      // the result state refills the output register itself
      if (out_valid && !out_stall && state != S_RESULT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            data_byte <= byte_in;
            res_byte  <= 8'd0;
            priority if (req_type == REQ_SCHEDULE) begin
              res_status <= STATUS_OK;
              n          <= 8'd0;
              state      <= S_INIT;
            end else if (req_type == REQ_DATA && scheduled) begin
              res_status <= STATUS_OK;
              idx_i      <= idx_i + 8'd1;
              state      <= S_DT_RD;
            end else begin
              res_status <= (req_type == REQ_DATA) ? STATUS_NO_SCHED : STATUS_OK;
              state      <= S_RESULT;
            end
          end
        end
        // identity fill
        S_INIT: begin
          n <= n + 8'd1;
          if (n == SBOX_LAST) begin
            idx_j <= 8'd0;
            kpos  <= '0;
            state <= S_KS_RD;
          end
        end
        // key schedule step
        S_KS_RD: begin
          state <= S_KS_J;
        end
        S_KS_J: begin
          si    <= sbox_rdata;
          idx_j <= jn;
          state <= S_KS_WN;
        end
        S_KS_WN: begin
          state <= S_KS_WJ;
        end
        S_KS_WJ: begin
          n <= n + 8'd1;
          if (9'(kpos) == len_m1) begin
            kpos <= '0;
          end else begin
            kpos <= KEY_AW'(kpos + 1'b1);
          end
          if (n == SBOX_LAST) begin
            idx_i     <= 8'd0;
            idx_j     <= 8'd0;
            scheduled <= 1'b1;
            state     <= S_RESULT;
          end else begin
            state <= S_KS_RD;
          end
        end
        // keystream generator step
        S_DT_RD: begin
          state <= S_DT_J;
        end
        S_DT_J: begin
          si    <= sbox_rdata;
          idx_j <= jn;
          state <= S_DT_WI;
        end
        S_DT_WI: begin
          sj     <= sbox_rdata;
          t_addr <= si + sbox_rdata;
          state  <= S_DT_WJ;
        end
        S_DT_WJ: begin
          res_byte <= data_byte ^ ks;
          state    <= S_RESULT;
        end
        // hand the result to the output register
        S_RESULT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_byte  <= res_byte;
            status    <= res_status;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // sbox permutation table
  rc4_ram #(
    .WIDTH (8),
    .DEPTH (SBOX_DEPTH)
  ) u_sbox (
    .clk   (clk),
    .we    (sbox_we),
    .waddr (sbox_waddr),
    .wdata (sbox_wdata),
    .raddr (sbox_raddr),
    .rdata (sbox_rdata)
  );

  // key store
  rc4_ram #(
    .WIDTH (8),
    .DEPTH (KEY_STORE_DEPTH)
  ) u_key_store (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_index[KEY_AW-1:0]),
    .wdata (byte_in),
    .raddr (kpos),
    .rdata (key_rdata)
  );

endmodule
